// ===== rtl/core/tcw_pkg.sv =====
// Shared constants, types and codes of the text console writer.
package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam int ADDR_W  = $clog2(CELLS);
    localparam int CUR_W   = $clog2(CELLS + 1);
    localparam int COL_W   = $clog2(COLUMNS);

    // widths fixed by the port list
    localparam int OP_W    = 2;
    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int IDX_W   = 11;
    localparam int CELL_W  = CHAR_W + ATTR_W;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 3;

    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

    localparam logic [CFG_AW-1:0] REG_FG     = 3'd0;
    localparam logic [CFG_AW-1:0] REG_BRIGHT = 3'd1;
    localparam logic [CFG_AW-1:0] REG_BG     = 3'd2;
    localparam logic [CFG_AW-1:0] REG_BLINK  = 3'd3;

    localparam logic [CHAR_W-1:0] NEWLINE    = 8'd10;
    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h8A;

    // one cell: character in the upper byte, attribute in the lower
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic              valid;
        logic [CHAR_W-1:0] rchar;
        logic [ATTR_W-1:0] rattr;
        logic [CUR_W-1:0]  cursor;
    } t_result;

endpackage

// ===== rtl/core/text_console_writer.sv =====
// Top level of the text console writer: configuration, output register, sequencer and memory.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one operation per transfer:
//   put character, clear screen or read cell. Output channel (o_out_valid /
//   i_out_stall) returns exactly one result per operation: the read cell
//   (zero unless a read of a cell on screen) and the cursor after it.
//   Configuration (i_cfg_we / i_cfg_addr / i_cfg_data) sets the attribute
//   fields; write it only while no operation is in flight.
// Sequence:
//   Put or newline goes straight to the result state. Read first passes a
//   read state, set by the registered read port of the cell memory. Put past
//   the last cell scrolls: the sequencer sweeps every cell through the single
//   memory port pair, then writes the glyph, if any, in a state of its own.
//   Clear sweeps every cell. The input is stalled for the whole sweep.
// Reset:
//   Synchronous, active low. After reset a clearing pass over every cell
//   blanks the screen with the reset attribute; inputs stall meanwhile,
//   configuration writes are taken.
// Back pressure:
//   A result waits in the output register; the next operation is still taken
//   and runs, and its result holds in the sequencer until the register frees.
module text_console_writer
    import tcw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic [IDX_W-1:0]  i_cell_index,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [CHAR_W-1:0] o_read_char,
    output logic [ATTR_W-1:0] o_read_attr,
    output logic [IDX_W-1:0]  o_cursor_pos,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    // attribute fields
    logic [2:0]        r_fg;
    logic              r_bright;
    logic [2:0]        r_bg;
    logic              r_blink;
    logic [ATTR_W-1:0] w_attr;

    // output register
    logic              r_out_valid;
    logic [CHAR_W-1:0] r_out_char;
    logic [ATTR_W-1:0] r_out_attr;
    logic [IDX_W-1:0]  r_out_cursor;
    logic              w_slot_free;

    t_result           w_res;
    t_ram_req          w_ram_req;
    logic [CELL_W-1:0] w_ram_rdata;

    assign w_attr = {r_blink, r_bg, r_bright, r_fg};

    // Write one attribute field; ignore indexes past the last register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg     <= RESET_ATTR[2:0];
            r_bright <= RESET_ATTR[3];
            r_bg     <= RESET_ATTR[6:4];
            r_blink  <= RESET_ATTR[7];
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_FG:     r_fg     <= i_cfg_data[2:0];
                REG_BRIGHT: r_bright <= i_cfg_data[0];
                REG_BG:     r_bg     <= i_cfg_data[2:0];
                REG_BLINK:  r_blink  <= i_cfg_data[0];
                default:    ;
            endcase
        end
    end

    // The register frees when empty or when its transfer completes now.
    assign w_slot_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res.valid && w_slot_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Load payload only with a new result; hold it while stalled.
    always_ff @(posedge i_clk) begin
        if (w_res.valid && w_slot_free) begin
            r_out_char   <= w_res.rchar;
            r_out_attr   <= w_res.rattr;
            r_out_cursor <= IDX_W'(w_res.cursor);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_char  = r_out_char;
    assign o_read_attr  = r_out_attr;
    assign o_cursor_pos = r_out_cursor;

    tcw_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_char_code  (i_char_code),
        .i_cell_index (i_cell_index),
        .i_attr       (w_attr),
        .i_slot_free  (w_slot_free),
        .o_res        (w_res),
        .o_ram_req    (w_ram_req),
        .i_ram_rdata  (w_ram_rdata)
    );

    tcw_cell_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (w_ram_req),
        .o_rdata (w_ram_rdata)
    );

endmodule

// ===== rtl/core/tcw_cell_ram.sv =====
// Screen cell memory: one write port, one registered read port.
module tcw_cell_ram
    import tcw_pkg::*;
(
    input  logic              i_clk,
    input  t_ram_req          i_req,
    output logic [CELL_W-1:0] o_rdata
);

    logic [CELL_W-1:0] r_mem [CELLS];
    logic [CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/tcw_ctrl.sv =====
// Operation sequencer: put, newline, scroll, clear and read against the cell memory.
module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic [IDX_W-1:0]  i_cell_index,
    input  logic [ATTR_W-1:0] i_attr,
    input  logic              i_slot_free,
    output t_result           o_res,
    output t_ram_req          o_ram_req,
    input  logic [CELL_W-1:0] i_ram_rdata
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FILL   = 3'd1;
    localparam logic [2:0] S_SCROLL = 3'd2;
    localparam logic [2:0] S_PUT    = 3'd3;
    localparam logic [2:0] S_READ   = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    localparam logic [CUR_W-1:0] CUR_CELLS = CUR_W'(CELLS);
    localparam logic [CUR_W-1:0] CUR_COLS  = CUR_W'(COLUMNS);
    localparam logic [CUR_W-1:0] CUR_BODY  = CUR_W'(CELLS - COLUMNS);
    localparam logic [COL_W-1:0] COL_LAST  = COL_W'(COLUMNS - 1);

    logic [2:0]        r_state, n_state;
    logic [CUR_W-1:0]  r_cnt, n_cnt;
    logic [CUR_W-1:0]  r_cursor, n_cursor;
    logic [COL_W-1:0]  r_col, n_col;
    logic [CHAR_W-1:0] r_code, n_code;
    logic              r_put_pend, n_put_pend;
    logic [ATTR_W-1:0] r_fill_attr, n_fill_attr;
    logic              r_fill_reply, n_fill_reply;
    logic [CHAR_W-1:0] r_res_char, n_res_char;
    logic [ATTR_W-1:0] r_res_attr, n_res_attr;

    logic [CUR_W-1:0]  w_src;
    logic [CUR_W-1:0]  w_dst;
    logic              w_idx_ok;

    assign w_src    = r_cnt + CUR_COLS;
    assign w_dst    = r_cnt - CUR_W'(1);
    assign w_idx_ok = 32'(i_cell_index) < 32'(CELLS);

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_res.valid  = (r_state == S_DONE);
    assign o_res.rchar  = r_res_char;
    assign o_res.rattr  = r_res_attr;
    assign o_res.cursor = r_cursor;

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_cursor     = r_cursor;
        n_col        = r_col;
        n_code       = r_code;
        n_put_pend   = r_put_pend;
        n_fill_attr  = r_fill_attr;
        n_fill_reply = r_fill_reply;
        n_res_char   = r_res_char;
        n_res_attr   = r_res_attr;
        o_ram_req.we    = 1'b0;
        o_ram_req.waddr = r_cursor[ADDR_W-1:0];
        o_ram_req.wdata = {r_code, i_attr};
        o_ram_req.raddr = w_src[ADDR_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_res_char = '0;
                    n_res_attr = '0;
                    n_state    = S_DONE;
                    unique case (i_operation)
                        OP_PUT: begin
                            if (r_cursor == CUR_CELLS) begin
                                // past the end: scroll first
                                n_code     = i_char_code;
                                n_put_pend = (i_char_code != NEWLINE);
                                n_cnt      = '0;
                                n_state    = S_SCROLL;
                            end else if (i_char_code == NEWLINE) begin
                                n_cursor = r_cursor - CUR_W'(r_col) + CUR_COLS;
                                n_col    = '0;
                            end else begin
                                o_ram_req.we    = 1'b1;
                                o_ram_req.wdata = {i_char_code, i_attr};
                                n_cursor = r_cursor + CUR_W'(1);
                                n_col    = (r_col == COL_LAST) ? '0 : r_col + COL_W'(1);
                            end
                        end
                        OP_CLEAR: begin
                            n_fill_attr  = i_attr;
                            n_fill_reply = 1'b1;
                            n_cnt        = '0;
                            n_state      = S_FILL;
                        end
                        OP_READ: begin
                            o_ram_req.raddr = ADDR_W'(i_cell_index);
                            if (w_idx_ok) begin
                                n_state = S_READ;
                            end
                        end
                        OP_NOP: begin
                            n_state = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_FILL: begin
                o_ram_req.we    = 1'b1;
                o_ram_req.waddr = r_cnt[ADDR_W-1:0];
                o_ram_req.wdata = {{CHAR_W{1'b0}}, r_fill_attr};
                if (r_cnt == CUR_CELLS - CUR_W'(1)) begin
                    n_state = r_fill_reply ? S_DONE : S_IDLE;
                end else begin
                    n_cnt = r_cnt + CUR_W'(1);
                end
            end
            S_SCROLL: begin
                // read one row ahead, write the word read in the previous cycle
                if (r_cnt != '0) begin
                    o_ram_req.we    = 1'b1;
                    o_ram_req.waddr = w_dst[ADDR_W-1:0];
                    o_ram_req.wdata = (r_cnt <= CUR_BODY) ? i_ram_rdata
                                                         : {{CHAR_W{1'b0}}, i_attr};
                end
                if (r_cnt == CUR_CELLS) begin
                    n_cursor = CUR_BODY;
                    n_col    = '0;
                    n_state  = r_put_pend ? S_PUT : S_DONE;
                end else begin
                    n_cnt = r_cnt + CUR_W'(1);
                end
            end
            S_PUT: begin
                o_ram_req.we = 1'b1;
                n_cursor = r_cursor + CUR_W'(1);
                n_col    = (r_col == COL_LAST) ? '0 : r_col + COL_W'(1);
                n_state  = S_DONE;
            end
            S_READ: begin
                n_res_char = i_ram_rdata[CELL_W-1:ATTR_W];
                n_res_attr = i_ram_rdata[ATTR_W-1:0];
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_FILL;
            r_cnt        <= '0;
            r_cursor     <= '0;
            r_col        <= '0;
            r_put_pend   <= 1'b0;
            r_fill_attr  <= RESET_ATTR;
            r_fill_reply <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_cursor     <= n_cursor;
            r_col        <= n_col;
            r_put_pend   <= n_put_pend;
            r_fill_attr  <= n_fill_attr;
            r_fill_reply <= n_fill_reply;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code     <= n_code;
        r_res_char <= n_res_char;
        r_res_attr <= n_res_attr;
    end

endmodule

// ===== rtl/core/tcw_checker.sv =====
// Port-level checks of the text console writer and their binding.
module tcw_checker
    import tcw_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic [OP_W-1:0]   i_operation,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [CHAR_W-1:0] o_read_char,
    input logic [ATTR_W-1:0] o_read_attr,
    input logic [IDX_W-1:0]  o_cursor_pos
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_read_char)
            && $stable(o_read_attr) && $stable(o_cursor_pos))
        else $error("stalled result changed");

    // the cursor never passes the end position
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_cursor_pos) <= 32'(CELLS))
        else $error("cursor beyond screen");

    // the clearing pass after reset stalls the input
    a_reset_pass: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input taken during reset clearing pass");

    // a clear sweeps the screen, so the next cycle stalls
    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_operation == OP_CLEAR |=> o_in_stall)
        else $error("clear did not stall the input");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);
